[src/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, codes and constants of the MIPS-I integer step unit.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int COP0_REG_COUNT = 32;
  localparam int C0_IDX_W = $clog2(COP0_REG_COUNT);

  localparam logic [C0_IDX_W-1:0] C0_BADVADDR = C0_IDX_W'(8);
  localparam logic [C0_IDX_W-1:0] C0_STATUS   = C0_IDX_W'(12);
  localparam logic [C0_IDX_W-1:0] C0_CAUSE    = C0_IDX_W'(13);
  localparam logic [C0_IDX_W-1:0] C0_EPC      = C0_IDX_W'(14);

  localparam logic [31:0] PC_RESET     = 32'hBFC0_0000;
  localparam logic [31:0] VEC_RAM      = 32'h8000_0080;
  localparam logic [31:0] VEC_ROM      = 32'hBFC0_0180;
  localparam logic [31:0] STATUS_RESET = 32'h1000_0000;
  localparam int          STATUS_ISC   = 16;
  localparam int          STATUS_BEV   = 22;

  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_READ  = 2'd1;
  localparam logic [1:0] MOP_WRITE = 2'd2;

  localparam logic [2:0] EXC_NONE = 3'd0;
  localparam logic [2:0] EXC_ADEL = 3'd1;
  localparam logic [2:0] EXC_ADES = 3'd2;
  localparam logic [2:0] EXC_SYS  = 3'd3;
  localparam logic [2:0] EXC_BP   = 3'd4;
  localparam logic [2:0] EXC_RI   = 3'd5;
  localparam logic [2:0] EXC_OV   = 3'd6;

  localparam logic [2:0] LK_NONE = 3'd0;
  localparam logic [2:0] LK_LB   = 3'd1;
  localparam logic [2:0] LK_LBU  = 3'd2;
  localparam logic [2:0] LK_LH   = 3'd3;
  localparam logic [2:0] LK_LHU  = 3'd4;
  localparam logic [2:0] LK_LW   = 3'd5;
  localparam logic [2:0] LK_LWL  = 3'd6;
  localparam logic [2:0] LK_LWR  = 3'd7;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BCOND   = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDI_U  = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTI_U  = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;
  localparam logic [5:0] FN_RFE     = 6'h10;

  localparam logic [4:0] RS_MFC0 = 5'd0;
  localparam logic [4:0] RS_MTC0 = 5'd4;
  localparam logic [4:0] RS_CO   = 5'h10;

  typedef struct packed {
    logic [1:0] off;
    logic [4:0] rd;
    logic [2:0] kind;
  } pend_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [4:0] exc_code(input logic [2:0] kind);
    logic [4:0] c;
    unique case (kind)
      EXC_ADEL: c = 5'd4;
      EXC_ADES: c = 5'd5;
      EXC_SYS:  c = 5'd8;
      EXC_BP:   c = 5'd9;
      EXC_RI:   c = 5'd10;
      EXC_OV:   c = 5'd12;
      default:  c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

[src/mcs_regfile.sv]
// ----------------------------------------------------------------------------
// mcs_regfile
// General register file: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcs_regfile
  import mcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  ra_addr,
  input  logic [4:0]  rb_addr,
  output logic [31:0] ra_data,
  output logic [31:0] rb_data,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [31:0] wr_data
);

  logic [31:0] mem [32];
  logic [31:0] written;
  logic [31:0] ra_q;
  logic [31:0] rb_q;
  logic        ra_ok;
  logic        rb_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ra_q <= mem[ra_addr];
      rb_q <= mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ra_ok   <= 1'b0;
      rb_ok   <= 1'b0;
    end else begin
      if (wr_en && wr_addr != 5'd0) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        ra_ok <= written[ra_addr] && ra_addr != 5'd0;
        rb_ok <= written[rb_addr] && rb_addr != 5'd0;
      end
    end
  end

  assign ra_data = ra_ok ? ra_q : 32'd0;
  assign rb_data = rb_ok ? rb_q : 32'd0;

endmodule

[src/mcs_div.sv]
// ----------------------------------------------------------------------------
// mcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcs_div
  import mcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic        fin;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= 32'd0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = fin;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

[src/mips1_integer_core_step_unit.sv]
// ----------------------------------------------------------------------------
// mips1_integer_core_step_unit
// MIPS-I integer core that executes one instruction or load return per word.
//
// The input channel (in_valid/in_ready) carries a command, an instruction
// word and load data. Command 0 executes the instruction fetched at the last
// reported fetch address unless a load is pending; command 1 returns the
// memory word for a pending load. Every input word yields exactly one output
// word on the output channel (out_valid/out_ready): next fetch address,
// memory request, and the kind of exception raised, if any.
// The register file is a synchronous memory read when a word is accepted;
// the instruction executes and writes back in the following cycle, and its
// result goes to the output registers then, unless the receiver stalls.
// DIVU with a nonzero divisor, and DIV with one except 0x8000_0000 / -1, run
// through a one-bit-per-cycle divider; no new word is accepted until it ends.
// A new word is accepted while an earlier result still waits on the output.
// If the receiver stalls, the finished result is parked and no further word
// is accepted until it leaves. Reset clears the register file valid bits,
// HI/LO, coprocessor 0 (Status keeps its reset value) and sets the program
// counter to the boot vector; the first result appears only after a word.
// ----------------------------------------------------------------------------
module mips1_integer_core_step_unit
  import mcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] instr_word,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fetch_address,
  output logic [1:0]  mem_op,
  output logic [31:0] mem_address,
  output logic [31:0] mem_write_data,
  output logic [3:0]  mem_byte_enable,
  output logic        awaiting_load,
  output logic [2:0]  exception_kind
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic        accept;
  logic        out_free;
  logic        load_out;
  logic        from_res;

  logic        cmd_q;
  logic [31:0] w_q;
  logic [31:0] ld_q;

  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] pc;
  logic [31:0] bt;
  logic        bp;
  pend_t       pend;
  logic [31:0] cop0 [COP0_REG_COUNT];

  logic [31:0] s;
  logic [31:0] t;
  logic        gwe;
  logic [4:0]  gwa;
  logic [31:0] gwd;

  logic [31:0] hi_next;
  logic [31:0] lo_next;
  logic [31:0] pc_next;
  logic [31:0] bt_next;
  logic        bp_next;
  pend_t       pend_next;
  logic [2:0]  kind;
  logic [1:0]  mop;
  logic [31:0] maddr;
  logic [31:0] wdata;
  logic [3:0]  be;
  logic [2:0]  lk;
  logic        mtc0;
  logic        rfe;
  logic        badv_we;
  logic        run;

  logic [5:0]  opc;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [5:0]  fn;
  logic [4:0]  sa;
  logic [31:0] imm;
  logic [31:0] a;
  logic [31:0] brt;
  logic [31:0] sum;
  logic [31:0] dif;
  logic [1:0]  off;
  logic [4:0]  lsh;
  logic [31:0] v;
  logic [65:0] prod;
  logic [C0_IDX_W-1:0] c0_idx;
  logic        c0_ok;
  logic [31:0] st;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        qneg;
  logic        rneg;
  logic        qneg_q;
  logic        rneg_q;

  logic [31:0] res_fetch;
  logic [1:0]  res_mop;
  logic [31:0] res_maddr;
  logic [31:0] res_wdata;
  logic [3:0]  res_be;
  logic        res_await;
  logic [2:0]  res_kind;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign run      = (state == S_EXEC);

  mcs_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .ra_addr (command ? pend.rd : instr_word[25:21]),
    .rb_addr (instr_word[20:16]),
    .ra_data (s),
    .rb_data (t),
    .wr_en   (run && gwe),
    .wr_addr (gwa),
    .wr_data (gwd)
  );

  mcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign opc    = w_q[31:26];
  assign rs     = w_q[25:21];
  assign rt     = w_q[20:16];
  assign rd     = w_q[15:11];
  assign sa     = w_q[10:6];
  assign fn     = w_q[5:0];
  assign imm    = {{16{w_q[15]}}, w_q[15:0]};
  assign a      = s + imm;
  assign brt    = pc + 32'd4 + {imm[29:0], 2'b00};
  assign sum    = s + t;
  assign dif    = s - t;
  assign off    = a[1:0];
  assign prod   = $signed({fn == FN_MULT && s[31], s}) * $signed({fn == FN_MULT && t[31], t});
  assign c0_idx = C0_IDX_W'(rd);
  assign c0_ok  = 32'(rd) < COP0_REG_COUNT;
  assign st     = cop0[C0_STATUS];
  assign lsh    = {pend.off, 3'b000};

  function automatic logic [3:0] pc_plus4_top(input logic [31:0] p);
    logic [31:0] n;
    n = p + 32'd4;
    return n[31:28];
  endfunction

  always_comb begin
    unique case (pend.kind)
      LK_LB:   v = {{24{ld_q[lsh + 5'd7]}}, 8'(ld_q >> lsh)};
      LK_LBU:  v = {24'd0, 8'(ld_q >> lsh)};
      LK_LH:   v = {{16{ld_q[{pend.off[1], 4'hF}]}}, 16'(ld_q >> {pend.off[1], 4'h0})};
      LK_LHU:  v = {16'd0, 16'(ld_q >> {pend.off[1], 4'h0})};
      LK_LWL:  v = (pend.off == 2'd3) ? ld_q
                 : (ld_q << (5'd24 - lsh)) | (s & (32'h00FF_FFFF >> lsh));
      LK_LWR:  v = (pend.off == 2'd0) ? ld_q
                 : (ld_q >> lsh) | (s & ~(32'hFFFF_FFFF >> lsh));
      default: v = ld_q;
    endcase
  end

  always_comb begin
    gwe       = 1'b0;
    gwa       = rd;
    gwd       = 32'd0;
    hi_next   = hi;
    lo_next   = lo;
    pc_next   = pc;
    bt_next   = bt;
    bp_next   = bp;
    pend_next = pend;
    kind      = EXC_NONE;
    mop       = MOP_NONE;
    maddr     = 32'd0;
    wdata     = 32'd0;
    be        = 4'd0;
    lk        = LK_NONE;
    mtc0      = 1'b0;
    rfe       = 1'b0;
    badv_we   = 1'b0;
    qneg      = 1'b0;
    rneg      = 1'b0;
    dreq      = '0;
    if (cmd_q || pend.kind != LK_NONE) begin
      if (cmd_q && pend.kind != LK_NONE) begin
        gwe       = 1'b1;
        gwa       = pend.rd;
        gwd       = v;
        pend_next = '0;
      end
    end else begin
      pc_next = bp ? bt : pc + 32'd4;
      bp_next = 1'b0;
      case (opc)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL:  begin gwe = 1'b1; gwd = t << sa; end
            FN_SRL:  begin gwe = 1'b1; gwd = t >> sa; end
            FN_SRA:  begin gwe = 1'b1; gwd = $signed(t) >>> sa; end
            FN_SLLV: begin gwe = 1'b1; gwd = t << s[4:0]; end
            FN_SRLV: begin gwe = 1'b1; gwd = t >> s[4:0]; end
            FN_SRAV: begin gwe = 1'b1; gwd = $signed(t) >>> s[4:0]; end
            FN_JR:   begin bp_next = 1'b1; bt_next = s; end
            FN_JALR: begin
              bp_next = 1'b1;
              bt_next = s;
              gwe     = 1'b1;
              gwd     = pc + 32'd8;
            end
            FN_SYSCALL: kind = EXC_SYS;
            FN_BREAK:   kind = EXC_BP;
            FN_MFHI: begin gwe = 1'b1; gwd = hi; end
            FN_MTHI: hi_next = s;
            FN_MFLO: begin gwe = 1'b1; gwd = lo; end
            FN_MTLO: lo_next = s;
            FN_MULT, FN_MULTU: begin
              hi_next = prod[63:32];
              lo_next = prod[31:0];
            end
            FN_DIV: begin
              if (t == 32'd0) begin
                hi_next = s;
                lo_next = s[31] ? 32'd1 : 32'hFFFF_FFFF;
              end else if (s == 32'h8000_0000 && t == 32'hFFFF_FFFF) begin
                hi_next = 32'd0;
                lo_next = 32'h8000_0000;
              end else begin
                dreq.start    = 1'b1;
                dreq.dividend = s[31] ? 32'd0 - s : s;
                dreq.divisor  = t[31] ? 32'd0 - t : t;
                qneg          = s[31] ^ t[31];
                rneg          = s[31];
              end
            end
            FN_DIVU: begin
              if (t == 32'd0) begin
                hi_next = s;
                lo_next = 32'hFFFF_FFFF;
              end else begin
                dreq.start    = 1'b1;
                dreq.dividend = s;
                dreq.divisor  = t;
              end
            end
            FN_ADD: begin
              if (((s ^ sum) & (t ^ sum) & 32'h8000_0000) != 32'd0) begin
                kind = EXC_OV;
              end else begin
                gwe = 1'b1;
                gwd = sum;
              end
            end
            FN_ADDU: begin gwe = 1'b1; gwd = sum; end
            FN_SUB: begin
              if (((s ^ t) & (s ^ dif) & 32'h8000_0000) != 32'd0) begin
                kind = EXC_OV;
              end else begin
                gwe = 1'b1;
                gwd = dif;
              end
            end
            FN_SUBU: begin gwe = 1'b1; gwd = dif; end
            FN_AND:  begin gwe = 1'b1; gwd = s & t; end
            FN_OR:   begin gwe = 1'b1; gwd = s | t; end
            FN_XOR:  begin gwe = 1'b1; gwd = s ^ t; end
            FN_NOR:  begin gwe = 1'b1; gwd = ~(s | t); end
            FN_SLT:  begin gwe = 1'b1; gwd = {31'd0, $signed(s) < $signed(t)}; end
            FN_SLTU: begin gwe = 1'b1; gwd = {31'd0, s < t}; end
            default: kind = EXC_RI;
          endcase
        end
        OP_BCOND: begin
          if (rt[3:1] == 3'd0) begin
            if (rt[4]) begin
              gwe = 1'b1;
              gwa = 5'd31;
              gwd = pc + 32'd8;
            end
            if (rt[0] ? !s[31] : s[31]) begin
              bp_next = 1'b1;
              bt_next = brt;
            end
          end else begin
            kind = EXC_RI;
          end
        end
        OP_J, OP_JAL: begin
          bp_next = 1'b1;
          bt_next = {pc_plus4_top(pc), w_q[25:0], 2'b00};
          if (opc == OP_JAL) begin
            gwe = 1'b1;
            gwa = 5'd31;
            gwd = pc + 32'd8;
          end
        end
        OP_BEQ:  if (s == t) begin bp_next = 1'b1; bt_next = brt; end
        OP_BNE:  if (s != t) begin bp_next = 1'b1; bt_next = brt; end
        OP_BLEZ: if (s == 32'd0 || s[31]) begin bp_next = 1'b1; bt_next = brt; end
        OP_BGTZ: if (s != 32'd0 && !s[31]) begin bp_next = 1'b1; bt_next = brt; end
        OP_ADDI: begin
          gwa = rt;
          if (((s ^ a) & (imm ^ a) & 32'h8000_0000) != 32'd0) begin
            kind = EXC_OV;
          end else begin
            gwe = 1'b1;
            gwd = a;
          end
        end
        OP_ADDI_U: begin gwa = rt; gwe = 1'b1; gwd = a; end
        OP_SLTI:   begin gwa = rt; gwe = 1'b1; gwd = {31'd0, $signed(s) < $signed(imm)}; end
        OP_SLTI_U: begin gwa = rt; gwe = 1'b1; gwd = {31'd0, s < imm}; end
        OP_ANDI:  begin gwa = rt; gwe = 1'b1; gwd = s & {16'd0, w_q[15:0]}; end
        OP_ORI:   begin gwa = rt; gwe = 1'b1; gwd = s | {16'd0, w_q[15:0]}; end
        OP_XORI:  begin gwa = rt; gwe = 1'b1; gwd = s ^ {16'd0, w_q[15:0]}; end
        OP_LUI:   begin gwa = rt; gwe = 1'b1; gwd = {w_q[15:0], 16'd0}; end
        OP_COP0: begin
          if (rs == RS_MFC0) begin
            gwa = rt;
            gwe = 1'b1;
            gwd = c0_ok ? cop0[c0_idx] : 32'd0;
          end else if (rs == RS_MTC0) begin
            mtc0 = c0_ok;
          end else if (rs[4] && fn == FN_RFE) begin
            rfe = 1'b1;
          end else begin
            kind = EXC_RI;
          end
        end
        OP_LB:  lk = LK_LB;
        OP_LBU: lk = LK_LBU;
        OP_LH:  lk = LK_LH;
        OP_LHU: lk = LK_LHU;
        OP_LW:  lk = LK_LW;
        OP_LWL: lk = LK_LWL;
        OP_LWR: lk = LK_LWR;
        OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: begin
          if ((opc == OP_SH && a[0]) || (opc == OP_SW && off != 2'd0)) begin
            kind    = EXC_ADES;
            badv_we = 1'b1;
          end else if (!st[STATUS_ISC]) begin
            case (opc)
              OP_SB: begin
                be    = 4'd1 << off;
                wdata = {24'd0, t[7:0]} << {off, 3'b000};
              end
              OP_SH: begin
                be    = 4'd3 << off;
                wdata = {16'd0, t[15:0]} << {off, 3'b000};
              end
              OP_SWL: begin
                be    = 4'hF >> (2'd3 - off);
                wdata = t >> {2'd3 - off, 3'b000};
              end
              OP_SW: begin
                be    = 4'hF;
                wdata = t;
              end
              default: begin
                be    = 4'hF << off;
                wdata = t << {off, 3'b000};
              end
            endcase
            mop   = MOP_WRITE;
            maddr = {a[31:2], 2'b00};
          end
        end
        default: kind = EXC_RI;
      endcase
      if (lk != LK_NONE) begin
        if ((lk == LK_LW && off != 2'd0) || ((lk == LK_LH || lk == LK_LHU) && a[0])) begin
          kind    = EXC_ADEL;
          badv_we = 1'b1;
        end else begin
          pend_next = '{off: off, rd: rt, kind: lk};
          mop       = MOP_READ;
          maddr     = {a[31:2], 2'b00};
        end
      end
      if (kind != EXC_NONE) begin
        bp_next = 1'b0;
        pc_next = st[STATUS_BEV] ? VEC_ROM : VEC_RAM;
        gwe     = 1'b0;
        dreq    = '0;
      end
    end
    if (gwa == 5'd0) begin
      gwe = 1'b0;
    end
    if (!run) begin
      dreq = '0;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    from_res   = 1'b0;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if (dreq.start) begin
          state_next = S_DIV;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: if (drsp.done) state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          from_res   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      w_q   <= instr_word;
      ld_q  <= load_data;
    end
    if (run) begin
      res_fetch <= pc_next;
      res_mop   <= mop;
      res_maddr <= maddr;
      res_wdata <= wdata;
      res_be    <= be;
      res_await <= pend_next.kind != LK_NONE;
      res_kind  <= kind;
      qneg_q    <= qneg;
      rneg_q    <= rneg;
    end
    if (load_out) begin
      fetch_address   <= from_res ? res_fetch : pc_next;
      mem_op          <= from_res ? res_mop : mop;
      mem_address     <= from_res ? res_maddr : maddr;
      mem_write_data  <= from_res ? res_wdata : wdata;
      mem_byte_enable <= from_res ? res_be : be;
      awaiting_load   <= from_res ? res_await : (pend_next.kind != LK_NONE);
      exception_kind  <= from_res ? res_kind : kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hi        <= 32'd0;
      lo        <= 32'd0;
      pc        <= PC_RESET;
      bt        <= 32'd0;
      bp        <= 1'b0;
      pend      <= '0;
      for (int i = 0; i < COP0_REG_COUNT; i++) begin
        cop0[i] <= (C0_IDX_W'(i) == C0_STATUS) ? STATUS_RESET : 32'd0;
      end
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (run) begin
        hi   <= hi_next;
        lo   <= lo_next;
        pc   <= pc_next;
        bt   <= bt_next;
        bp   <= bp_next;
        pend <= pend_next;
        if (mtc0) begin
          cop0[c0_idx] <= t;
        end
        if (rfe) begin
          cop0[C0_STATUS] <= {st[31:4], st[5:2]};
        end
        if (badv_we) begin
          cop0[C0_BADVADDR] <= a;
        end
        if (kind != EXC_NONE) begin
          cop0[C0_STATUS] <= {st[31:6], st[3:0], 2'b00};
          cop0[C0_CAUSE]  <= {bp, 24'd0, exc_code(kind), 2'b00};
          cop0[C0_EPC]    <= bp ? pc - 32'd4 : pc;
        end
      end
      if (state == S_DIV && drsp.done) begin
        lo <= qneg_q ? 32'd0 - drsp.quot : drsp.quot;
        hi <= rneg_q ? 32'd0 - drsp.rem : drsp.rem;
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIPS-I integer step unit.
//
// A directed sequence covers arithmetic traps, the divide corner cases,
// word and partial-word loads and stores, a byte store, cache isolate,
// the coprocessor-0 operations and the exceptions. Random instruction
// words follow, most of them well formed, with a load return mostly sent
// while the core waits for one. A predictor tracks the architectural state
// and computes and checks, in order, the output word of every accepted word.
// ----------------------------------------------------------------------------
module tb;
  import mcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] fa;
    logic [1:0]  mop;
    logic [31:0] maddr;
    logic [31:0] wdata;
    logic [3:0]  be;
    logic        aw;
    logic [2:0]  exc;
  } step_res_t;

  class core_scoreboard;
    logic [31:0] gpr[32];
    logic [31:0] c0[32];
    logic [31:0] hi, lo, pc, btgt;
    bit          bpend, dslot;
    pend_t       pend;
    step_res_t   exp_q[$];
    int          fails;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (c0[i]) c0[i] = '0;
      c0[C0_STATUS] = STATUS_RESET;
      hi = '0; lo = '0; pc = PC_RESET; btgt = '0;
      bpend = 0; dslot = 0; pend = '0; fails = 0;
    endfunction

    function bit awaiting();
      return pend.kind != LK_NONE;
    endfunction

    function void wr(logic [4:0] r, logic [31:0] v);
      if (r != 0) gpr[r] = v;
    endfunction

    function void trap(logic [31:0] at, logic [2:0] k);
      logic [31:0] st;
      logic [4:0]  code;
      st = c0[C0_STATUS];
      code = exc_code(k);
      c0[C0_STATUS] = {st[31:6], st[3:0], 2'b00};
      c0[C0_CAUSE] = {25'd0, code, 2'b00};
      c0[C0_EPC] = at;
      if (dslot) begin
        c0[C0_EPC] = at - 4;
        c0[C0_CAUSE][31] = 1'b1;
      end
      bpend = 0;
      pc = st[STATUS_BEV] ? VEC_ROM : VEC_RAM;
    endfunction

    function void sdiv(logic [31:0] n, logic [31:0] d);
      logic [31:0] an, ad, q, r;
      if (d == 0) begin
        hi = n; lo = n[31] ? 32'd1 : 32'hFFFF_FFFF;
      end else if (n == 32'h8000_0000 && d == 32'hFFFF_FFFF) begin
        hi = 0; lo = 32'h8000_0000;
      end else begin
        an = n[31] ? -n : n;
        ad = d[31] ? -d : d;
        q = an / ad; r = an % ad;
        lo = (n[31] != d[31]) ? -q : q;
        hi = n[31] ? -r : r;
      end
    endfunction

    function void note(logic cmd, logic [31:0] w, logic [31:0] d);
      logic [5:0]  opc, fn;
      logic [4:0]  rs, rt, rd;
      logic [31:0] s, t, imm, a, cur, brt, v, old, r, maddr, wdata;
      logic [1:0]  off, mop;
      logic [3:0]  be;
      logic [2:0]  k, lk;
      logic signed [63:0] sp;
      logic [63:0] up;
      if (cmd || pend.kind != LK_NONE) begin
        if (cmd && pend.kind != LK_NONE) begin
          off = pend.off; old = gpr[pend.rd];
          case (pend.kind)
            LK_LB: begin v = d >> (8 * off); v = {{24{v[7]}}, v[7:0]}; end
            LK_LBU: v = (d >> (8 * off)) & 32'hFF;
            LK_LH: begin v = d >> (8 * (off & 2)); v = {{16{v[15]}}, v[15:0]}; end
            LK_LHU: v = (d >> (8 * (off & 2))) & 32'hFFFF;
            LK_LWL: v = (off == 3) ? d :
                        (d << (8 * (3 - off))) | (old & (32'h00FF_FFFF >> (8 * off)));
            LK_LWR: v = (off == 0) ? d :
                        (d >> (8 * off)) | (old & ~(32'hFFFF_FFFF >> (8 * off)));
            default: v = d;
          endcase
          wr(pend.rd, v);
          pend = '0;
        end
        exp_q.push_back('{pc, MOP_NONE, 32'd0, 32'd0, 4'd0, pend.kind != LK_NONE, EXC_NONE});
        return;
      end
      opc = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; fn = w[5:0];
      imm = {{16{w[15]}}, w[15:0]};
      s = gpr[rs]; t = gpr[rt];
      cur = pc;
      dslot = bpend;
      pc = bpend ? btgt : cur + 4;
      bpend = 0;
      brt = cur + 4 + (imm << 2);
      a = s + imm;
      k = EXC_NONE; mop = MOP_NONE; be = 0; lk = LK_NONE; maddr = 0; wdata = 0;
      case (opc)
        OP_SPECIAL:
          case (fn)
            FN_SLL:  wr(rd, t << w[10:6]);
            FN_SRL:  wr(rd, t >> w[10:6]);
            FN_SRA:  wr(rd, $signed(t) >>> w[10:6]);
            FN_SLLV: wr(rd, t << s[4:0]);
            FN_SRLV: wr(rd, t >> s[4:0]);
            FN_SRAV: wr(rd, $signed(t) >>> s[4:0]);
            FN_JR:   begin bpend = 1; btgt = s; end
            FN_JALR: begin bpend = 1; btgt = s; wr(rd, cur + 8); end
            FN_SYSCALL: k = EXC_SYS;
            FN_BREAK: k = EXC_BP;
            FN_MFHI: wr(rd, hi);
            FN_MTHI: hi = s;
            FN_MFLO: wr(rd, lo);
            FN_MTLO: lo = s;
            FN_MULT: begin sp = $signed(s) * $signed(t); hi = sp[63:32]; lo = sp[31:0]; end
            FN_MULTU: begin up = {32'd0, s} * {32'd0, t}; hi = up[63:32]; lo = up[31:0]; end
            FN_DIV: sdiv(s, t);
            FN_DIVU:
              if (t == 0) begin hi = s; lo = 32'hFFFF_FFFF; end
              else begin hi = s % t; lo = s / t; end
            FN_ADD: begin
              r = s + t;
              if ((s[31] ^ r[31]) & (t[31] ^ r[31])) k = EXC_OV; else wr(rd, r);
            end
            FN_ADDU: wr(rd, s + t);
            FN_SUB: begin
              r = s - t;
              if ((s[31] ^ t[31]) & (s[31] ^ r[31])) k = EXC_OV; else wr(rd, r);
            end
            FN_SUBU: wr(rd, s - t);
            FN_AND: wr(rd, s & t);
            FN_OR:  wr(rd, s | t);
            FN_XOR: wr(rd, s ^ t);
            FN_NOR: wr(rd, ~(s | t));
            FN_SLT: wr(rd, {31'd0, $signed(s) < $signed(t)});
            FN_SLTU: wr(rd, {31'd0, s < t});
            default: k = EXC_RI;
          endcase
        OP_BCOND:
          if (rt == 0 || rt == 1 || rt == 16 || rt == 17) begin
            if (rt[4]) wr(31, cur + 8);
            if (rt[0] ? !s[31] : s[31]) begin bpend = 1; btgt = brt; end
          end else k = EXC_RI;
        OP_J, OP_JAL: begin
          bpend = 1;
          btgt = ((cur + 32'd4) & 32'hF000_0000) | {4'd0, w[25:0], 2'b00};
          if (opc == OP_JAL) wr(31, cur + 8);
        end
        OP_BEQ:  if (s == t) begin bpend = 1; btgt = brt; end
        OP_BNE:  if (s != t) begin bpend = 1; btgt = brt; end
        OP_BLEZ: if (s == 0 || s[31]) begin bpend = 1; btgt = brt; end
        OP_BGTZ: if (s != 0 && !s[31]) begin bpend = 1; btgt = brt; end
        OP_ADDI:
          if ((s[31] ^ a[31]) & (imm[31] ^ a[31])) k = EXC_OV; else wr(rt, a);
        OP_ADDI_U: wr(rt, a);
        OP_SLTI:   wr(rt, {31'd0, $signed(s) < $signed(imm)});
        OP_SLTI_U: wr(rt, {31'd0, s < imm});
        OP_ANDI:  wr(rt, s & {16'd0, w[15:0]});
        OP_ORI:   wr(rt, s | {16'd0, w[15:0]});
        OP_XORI:  wr(rt, s ^ {16'd0, w[15:0]});
        OP_LUI:   wr(rt, {w[15:0], 16'd0});
        OP_COP0:
          if (rs == RS_MFC0) wr(rt, c0[rd]);
          else if (rs == RS_MTC0) c0[rd] = t;
          else if (rs[4] && fn == FN_RFE)
            c0[C0_STATUS] = {c0[C0_STATUS][31:4], c0[C0_STATUS][5:2]};
          else k = EXC_RI;
        OP_LB:  lk = LK_LB;
        OP_LBU: lk = LK_LBU;
        OP_LH:  lk = LK_LH;
        OP_LHU: lk = LK_LHU;
        OP_LW:  lk = LK_LW;
        OP_LWL: lk = LK_LWL;
        OP_LWR: lk = LK_LWR;
        OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: begin
          off = a[1:0];
          if ((opc == OP_SH && a[0]) || (opc == OP_SW && off != 0)) begin
            k = EXC_ADES; c0[C0_BADVADDR] = a;
          end else if (!c0[C0_STATUS][STATUS_ISC]) begin
            case (opc)
              OP_SB:  begin be = 4'b0001 << off; wdata = (t & 32'hFF) << (8 * off); end
              OP_SH:  begin be = 4'b0011 << off; wdata = (t & 32'hFFFF) << (8 * off); end
              OP_SWL: begin be = 4'hF >> (3 - off); wdata = t >> (8 * (3 - off)); end
              OP_SW:  begin be = 4'hF; wdata = t; end
              default: begin be = 4'hF << off; wdata = t << (8 * off); end
            endcase
            mop = MOP_WRITE; maddr = {a[31:2], 2'b00};
          end
        end
        default: k = EXC_RI;
      endcase
      if (lk != LK_NONE) begin
        if ((lk == LK_LW && a[1:0] != 0) || ((lk == LK_LH || lk == LK_LHU) && a[0])) begin
          k = EXC_ADEL; c0[C0_BADVADDR] = a;
        end else begin
          pend.kind = lk; pend.rd = rt; pend.off = a[1:0];
          mop = MOP_READ; maddr = {a[31:2], 2'b00};
        end
      end
      if (k != EXC_NONE) trap(cur, k);
      exp_q.push_back('{pc, mop, maddr, wdata, be, pend.kind != LK_NONE, k});
    endfunction

    function void check(step_res_t got);
      step_res_t e;
      if (exp_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected output word %p", got);
        return;
      end
      e = exp_q.pop_front();
      if (got.fa !== e.fa || got.mop !== e.mop || got.maddr !== e.maddr ||
          got.wdata !== e.wdata || got.be !== e.be || got.aw !== e.aw ||
          got.exc !== e.exc) begin
        fails++;
        if (fails <= 10) $display("mismatch: expected %p got %p", e, got);
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_ready, command = 0, out_valid, out_ready = 0;
  logic [31:0] instr_word = 0, load_data = 0;
  logic [31:0] fetch_address, mem_address, mem_write_data;
  logic [1:0]  mem_op;
  logic [3:0]  mem_byte_enable;
  logic        awaiting_load;
  logic [2:0]  exception_kind;

  core_scoreboard sb = new();
  bit calm = 0;
  int hold = 0;
  int cycles = 0;

  localparam int LIMIT = 400000;

  logic [5:0] fn_list[28] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
    FN_JALR, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
    FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
    FN_SLT, FN_SLTU};
  logic [5:0] imm_ops[8] = '{OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI,
    OP_XORI, OP_LUI};
  logic [5:0] br_ops[7] = '{OP_BCOND, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
  logic [5:0] ld_ops[7] = '{OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR};
  logic [5:0] st_ops[5] = '{OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR};

  mips1_integer_core_step_unit i_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (out_valid && out_ready)
      sb.check('{fetch_address, mem_op, mem_address, mem_write_data, mem_byte_enable,
                 awaiting_load, exception_kind});
  end

  always @(negedge clk) begin
    if (hold > 0) begin
      hold--;
      out_ready <= 0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] rand_instr();
    int c;
    c = $urandom_range(0, 99);
    if (c < 8) return $urandom;
    if (c < 40) return rtype(($urandom_range(0, 29) == 0) ? 6'($urandom) :
                             fn_list[$urandom_range(0, 27)],
                             pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
    if (c < 56) return itype(imm_ops[$urandom_range(0, 7)], pick_reg(), pick_reg(),
                             ($urandom_range(0, 1) != 0) ? 16'($urandom) : pick_imm());
    if (c < 65) return itype(br_ops[$urandom_range(0, 6)], pick_reg(),
                             ($urandom_range(0, 1) != 0) ? pick_reg() :
                             5'($urandom_range(0, 1) | ($urandom_range(0, 1) << 4)),
                             16'($urandom));
    if (c < 80) return itype(ld_ops[$urandom_range(0, 6)], pick_reg(), pick_reg(),
                             pick_imm());
    if (c < 92) return itype(st_ops[$urandom_range(0, 4)], pick_reg(), pick_reg(),
                             pick_imm());
    if (c < 97) begin
      case ($urandom_range(0, 3))
        0: return {OP_COP0, RS_MFC0, pick_reg(), 5'($urandom), 11'd0};
        1: return {OP_COP0, RS_MTC0, pick_reg(), 5'($urandom_range(8, 14)), 11'd0};
        2: return {OP_COP0, RS_CO, 15'd0, FN_RFE};
        default: return {OP_COP0, 5'($urandom), 16'($urandom), 6'($urandom)};
      endcase
    end
    case ($urandom_range(0, 2))
      0: return rtype(FN_SYSCALL, 0, 0, 0, 0);
      1: return rtype(FN_BREAK, 0, 0, 0, 0);
      default: return {OP_COP2, 26'($urandom)};
    endcase
  endfunction

  task automatic put(logic cmd, logic [31:0] w, logic [31:0] d);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    instr_word <= w;
    load_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note(cmd, w, d);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] w;
    logic        ld_now;
    int          n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    put(0, itype(OP_LUI, 0, 1, 16'h8000), 0);
    put(0, itype(OP_ADDI_U, 0, 2, 16'hFFFF), 0);
    put(0, rtype(FN_ADD, 1, 1, 3, 0), 0);
    put(0, rtype(FN_SUB, 0, 1, 3, 0), 0);
    put(0, itype(OP_ADDI, 1, 5, 16'hFFFF), 0);
    put(0, rtype(FN_DIV, 1, 2, 0, 0), 0);
    put(0, rtype(FN_MFLO, 0, 0, 4, 0), 0);
    put(0, rtype(FN_DIV, 2, 0, 0, 0), 0);
    put(0, rtype(FN_DIVU, 1, 0, 0, 0), 0);
    put(0, rtype(FN_MULT, 1, 2, 0, 0), 0);
    put(0, rtype(FN_MFHI, 0, 0, 4, 0), 0);
    put(0, itype(OP_SW, 0, 2, 16'h0001), 0);
    put(0, itype(OP_LW, 0, 6, 16'h0000), 0);
    put(0, 32'hFFFF_FFFF, 0);
    put(1, 0, 32'hFFFF_FFFF);
    put(1, 0, 32'h1234_5678);
    put(0, itype(OP_LWL, 0, 6, 16'h0001), 0);
    put(1, 0, 32'hA5A5_5A5A);
    put(0, itype(OP_LWR, 0, 6, 16'h0002), 0);
    put(1, 0, 32'h8765_4321);
    put(0, itype(OP_SWL, 0, 2, 16'h0001), 0);
    put(0, itype(OP_SWR, 0, 2, 16'h0002), 0);
    put(0, itype(OP_LUI, 0, 7, 16'h0041), 0);
    put(0, {OP_COP0, RS_MTC0, 5'd7, 5'd12, 11'd0}, 0);
    put(0, itype(OP_SB, 0, 2, 16'h0003), 0);
    put(0, rtype(FN_SYSCALL, 0, 0, 0, 0), 0);
    put(0, {OP_COP0, RS_CO, 15'd0, FN_RFE}, 0);
    put(0, itype(OP_BCOND, 1, 17, 16'h0010), 0);
    put(0, rtype(FN_BREAK, 0, 0, 0, 0), 0);
    put(0, {OP_COP2, 26'd0}, 0);
    put(0, itype(OP_LUI, 0, 7, 16'h1000), 0);
    put(0, {OP_COP0, RS_MTC0, 5'd7, 5'd12, 11'd0}, 0);
    drain();

    n = 0;
    while (n < 400) begin
      if (n == 120) hold = 300;
      calm = (n >= 200 && n < 280);
      if (n == 300) drain();
      ld_now = sb.awaiting() ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      w = ld_now ? 32'($urandom) : rand_instr();
      if (ld_now == sb.awaiting()) n++;
      put(ld_now, w, $urandom);
    end
    calm = 0;
    drain();
    repeat (80) @(posedge clk);
    if (sb.fails == 0 && sb.exp_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[mips1_integer_core_step_unit.f]
src/mcs_pkg.sv
src/mcs_regfile.sv
src/mcs_div.sv
src/mips1_integer_core_step_unit.sv
tb/sv/tb.sv
